[rtl/bbi_pkg.sv]
`timescale 1ns / 1ps
package bbi_pkg;

   localparam int FRAC_BITS_DEF = 16;

   typedef enum logic [1:0] {
      MODE_TICK   = 2'd0,
      MODE_BOUNCE = 2'd1,
      MODE_PLACE  = 2'd2,
      MODE_HIT    = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      REG_GRAVITY = 3'd0,
      REG_DRAG    = 3'd1,
      REG_WIND_X  = 3'd2,
      REG_WIND_Y  = 3'd3,
      REG_WIND_Z  = 3'd4,
      REG_KEEP    = 3'd5,
      REG_SELF    = 3'd6,
      REG_ARM     = 3'd7
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DRAG,
      ST_ACC,
      ST_ADT,
      ST_VDT,
      ST_HALF,
      ST_UPD,
      ST_BOUNCE,
      ST_FT,
      ST_SELF,
      ST_ARM,
      ST_SQ,
      ST_CMP,
      ST_OUT
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [71:0] x);
      if (x > 72'sd2147483647) begin
         sat32 = 32'sh7FFFFFFF;
      end else if (x < -72'sd2147483648) begin
         sat32 = 32'sh80000000;
      end else begin
         sat32 = x[31:0];
      end
   endfunction

endpackage

[rtl/bbi_if.sv]
`timescale 1ns / 1ps
interface bbi_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic [16:0]        time_step;
   logic signed [31:0] arm_force_x;
   logic signed [31:0] arm_force_y;
   logic signed [31:0] arm_force_z;
   logic [21:0]        charge_time;
   logic signed [31:0] place_x;
   logic signed [31:0] place_y;
   logic signed [31:0] place_z;
   modport source (output valid, mode, time_step, arm_force_x, arm_force_y, arm_force_z,
                   charge_time, place_x, place_y, place_z, input ready);
   modport sink (input valid, mode, time_step, arm_force_x, arm_force_y, arm_force_z,
                 charge_time, place_x, place_y, place_z, output ready);
endinterface

interface bbi_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;
   logic signed [31:0] vel_z;
   logic               airborne;
   logic               moving;
   logic [30:0]        since_impact;
   modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, airborne,
                   moving, since_impact, input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, airborne,
                 moving, since_impact, output ready);
endinterface

interface bbi_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[rtl/ballistic_ball_integrator.sv]
`timescale 1ns / 1ps
// Channel   Direction  Contents
// req       in         mode, time step, arm force, charge time, place position
// rsp       out        position, velocity, airborne, moving, time since impact
// csr       in         register index and write data
//
// A tick in flight runs six steps per axis, three squares, a compare and the output step;
// a bounce in flight scales each axis; an arm hit forms force, own-velocity and arm terms
// per axis; both then square, compare and take the output step. A place or a landed tick
// or bounce goes straight to the output step. One shared 32 x 32 multiplier forms at most
// one product a cycle. Once the result is taken, the next item can be accepted; a waiting
// result holds req.ready low. Synchronous reset clears the ball and restores the registers.
module ballistic_ball_integrator #(
   parameter int FRAC_BITS = bbi_pkg::FRAC_BITS_DEF
) (
   input logic clock,
   input logic reset,
   bbi_req_if.sink   req,
   bbi_rsp_if.source rsp,
   bbi_csr_if.sink   csr
);

   // Threshold for the moving flag: round(0.1 * 2^FRAC_BITS), squared.
   localparam longint SpeedMin = ((64'sd1 <<< FRAC_BITS) + 5) / 10;
   localparam logic [65:0] SpeedSq = 66'(SpeedMin * SpeedMin);

   logic [20:0]        gravity_ff;
   logic [15:0]        drag_ff;
   logic signed [31:0] wind_ff [3];
   logic [16:0]        keep_ff;
   logic signed [17:0] self_ff;
   logic [20:0]        arm_ff;

   logic signed [31:0] pos_ff [3];
   logic signed [31:0] vel_ff [3];
   logic               fly_ff, fast_ff;
   logic [30:0]        timer_ff;

   bbi_pkg::state_type state_ff, state_in;
   logic [1:0]         axis_ff, axis_in;
   logic [16:0]        dt_ff;
   logic [21:0]        charge_ff;
   logic signed [31:0] force_ff [3];
   logic signed [31:0] acc_ff, adt_ff, vdt_ff, tmp_ff;
   logic signed [33:0] gv_ff;   // own-velocity term of an arm hit, needs 34 bits
   logic signed [71:0] acc_wide;
   logic [65:0]        sq_ff;
   logic               rsp_valid_ff;

   // The shared multiplier: a 32-bit signed operand times a 32-bit signed one.
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] mul_p;
   logic signed [63:0] mul_q;   // product floored by FRAC_BITS
   assign mul_p = mul_a * mul_b;
   assign mul_q = mul_p >>> FRAC_BITS;

   logic signed [31:0] v_cur;
   assign v_cur = vel_ff[axis_ff];

   assign req.ready = (state_ff == bbi_pkg::ST_IDLE) && !rsp_valid_ff;
   assign csr.ready = 1'b1;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      acc_wide = '0;
      unique case (state_ff)
         bbi_pkg::ST_DRAG: begin
            mul_a = v_cur;
            mul_b = 32'(signed'({1'b0, drag_ff}));
         end
         bbi_pkg::ST_ADT: begin
            mul_a = acc_ff;
            mul_b = 32'(signed'({1'b0, dt_ff}));
         end
         bbi_pkg::ST_VDT: begin
            mul_a = v_cur;
            mul_b = 32'(signed'({1'b0, dt_ff}));
         end
         bbi_pkg::ST_HALF: begin
            mul_a = adt_ff;
            mul_b = 32'(signed'({1'b0, dt_ff}));
         end
         bbi_pkg::ST_BOUNCE: begin
            mul_a = v_cur;
            mul_b = 32'(signed'({1'b0, keep_ff}));
         end
         bbi_pkg::ST_FT: begin
            mul_a = force_ff[axis_ff];
            mul_b = 32'(signed'({1'b0, charge_ff}));
         end
         bbi_pkg::ST_SELF: begin
            mul_a = v_cur;
            mul_b = 32'(self_ff);
         end
         bbi_pkg::ST_ARM: begin
            mul_a = tmp_ff;
            mul_b = 32'(signed'({1'b0, arm_ff}));
         end
         bbi_pkg::ST_SQ: begin
            mul_a = v_cur;
            mul_b = v_cur;
         end
         default: begin
         end
      endcase
      // Acceleration: wind, less drag when moving, less gravity on y.
      acc_wide = 72'(wind_ff[axis_ff]) - (fast_ff ? 72'(acc_ff) : 72'sd0)
               - ((axis_ff == 2'd1) ? 72'(signed'({1'b0, gravity_ff})) : 72'sd0);
   end

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      unique case (state_ff)
         bbi_pkg::ST_IDLE: begin
            axis_in = 2'd0;
            if (req.valid && req.ready) begin
               unique case (bbi_pkg::mode_type'(req.mode))
                  bbi_pkg::MODE_TICK:   state_in = fly_ff ? bbi_pkg::ST_DRAG : bbi_pkg::ST_OUT;
                  bbi_pkg::MODE_BOUNCE: state_in = fly_ff ? bbi_pkg::ST_BOUNCE : bbi_pkg::ST_OUT;
                  bbi_pkg::MODE_PLACE:  state_in = bbi_pkg::ST_OUT;
                  default:              state_in = bbi_pkg::ST_FT;
               endcase
            end
         end
         bbi_pkg::ST_DRAG: state_in = bbi_pkg::ST_ACC;
         bbi_pkg::ST_ACC:  state_in = bbi_pkg::ST_ADT;
         bbi_pkg::ST_ADT:  state_in = bbi_pkg::ST_VDT;
         bbi_pkg::ST_VDT:  state_in = bbi_pkg::ST_HALF;
         bbi_pkg::ST_HALF: state_in = bbi_pkg::ST_UPD;
         bbi_pkg::ST_UPD: begin
            axis_in  = (axis_ff == 2'd2) ? 2'd0 : axis_ff + 2'd1;
            state_in = (axis_ff == 2'd2) ? bbi_pkg::ST_SQ : bbi_pkg::ST_DRAG;
         end
         bbi_pkg::ST_BOUNCE: begin
            axis_in  = (axis_ff == 2'd2) ? 2'd0 : axis_ff + 2'd1;
            state_in = (axis_ff == 2'd2) ? bbi_pkg::ST_SQ : bbi_pkg::ST_BOUNCE;
         end
         bbi_pkg::ST_FT:   state_in = bbi_pkg::ST_SELF;
         bbi_pkg::ST_SELF: state_in = bbi_pkg::ST_ARM;
         bbi_pkg::ST_ARM: begin
            axis_in  = (axis_ff == 2'd2) ? 2'd0 : axis_ff + 2'd1;
            state_in = (axis_ff == 2'd2) ? bbi_pkg::ST_SQ : bbi_pkg::ST_FT;
         end
         bbi_pkg::ST_SQ: begin
            axis_in  = (axis_ff == 2'd2) ? 2'd0 : axis_ff + 2'd1;
            state_in = (axis_ff == 2'd2) ? bbi_pkg::ST_CMP : bbi_pkg::ST_SQ;
         end
         bbi_pkg::ST_CMP: state_in = bbi_pkg::ST_OUT;
         bbi_pkg::ST_OUT: state_in = bbi_pkg::ST_IDLE;
         default:         state_in = bbi_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bbi_pkg::ST_IDLE;
         axis_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
         gravity_ff   <= 21'd642689;
         drag_ff      <= 16'd92;
         wind_ff[0]   <= '0;
         wind_ff[1]   <= '0;
         wind_ff[2]   <= '0;
         keep_ff      <= 17'd32768;
         self_ff      <= -18'sd30583;
         arm_ff       <= 21'd38229;
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= '0;
            vel_ff[i] <= '0;
         end
         fly_ff   <= 1'b0;
         fast_ff  <= 1'b0;
         timer_ff <= '0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         if (csr.valid) begin
            unique case (bbi_pkg::reg_index_type'(csr.index))
               bbi_pkg::REG_GRAVITY: gravity_ff <= csr.data[20:0];
               bbi_pkg::REG_DRAG:    drag_ff    <= csr.data[15:0];
               bbi_pkg::REG_WIND_X:  wind_ff[0] <= csr.data;
               bbi_pkg::REG_WIND_Y:  wind_ff[1] <= csr.data;
               bbi_pkg::REG_WIND_Z:  wind_ff[2] <= csr.data;
               bbi_pkg::REG_KEEP:    keep_ff    <= csr.data[16:0];
               bbi_pkg::REG_SELF:    self_ff    <= csr.data[17:0];
               default:              arm_ff     <= csr.data[20:0];
            endcase
         end
         if (state_ff == bbi_pkg::ST_OUT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.valid && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            bbi_pkg::ST_IDLE: begin
               if (req.valid && req.ready) begin
                  dt_ff       <= req.time_step;
                  charge_ff   <= req.charge_time;
                  force_ff[0] <= req.arm_force_x;
                  force_ff[1] <= req.arm_force_y;
                  force_ff[2] <= req.arm_force_z;
                  if (req.mode == bbi_pkg::MODE_TICK) begin
                     timer_ff <= ({1'b0, timer_ff} + 32'(req.time_step) > 32'h7FFFFFFF)
                                 ? 31'h7FFFFFFF : timer_ff + 31'(req.time_step);
                  end else begin
                     timer_ff <= '0;
                  end
                  if (req.mode == bbi_pkg::MODE_PLACE) begin
                     pos_ff[0] <= req.place_x;
                     pos_ff[1] <= req.place_y;
                     pos_ff[2] <= req.place_z;
                     for (int i = 0; i < 3; i++) vel_ff[i] <= '0;
                     fly_ff  <= 1'b0;
                     fast_ff <= 1'b0;
                  end
                  if (req.mode == bbi_pkg::MODE_HIT) begin
                     fly_ff <= 1'b1;
                  end
               end
            end
            bbi_pkg::ST_DRAG: acc_ff <= bbi_pkg::sat32(72'(mul_q));
            bbi_pkg::ST_ACC:  acc_ff <= bbi_pkg::sat32(acc_wide);
            bbi_pkg::ST_ADT:  adt_ff <= bbi_pkg::sat32(72'(mul_q));
            bbi_pkg::ST_VDT:  vdt_ff <= bbi_pkg::sat32(72'(mul_q));
            bbi_pkg::ST_HALF: tmp_ff <= 32'(mul_p >>> (FRAC_BITS + 1));
            bbi_pkg::ST_UPD: begin
               vel_ff[axis_ff] <= bbi_pkg::sat32(72'(v_cur) + 72'(adt_ff));
               pos_ff[axis_ff] <= bbi_pkg::sat32(72'(pos_ff[axis_ff]) + 72'(vdt_ff)
                                                 + 72'(tmp_ff));
            end
            bbi_pkg::ST_BOUNCE: begin
               vel_ff[axis_ff] <= bbi_pkg::sat32((axis_ff == 2'd1) ? -72'(mul_q)
                                                                   : 72'(mul_q));
            end
            bbi_pkg::ST_FT:   tmp_ff <= bbi_pkg::sat32(72'(mul_q));
            bbi_pkg::ST_SELF: gv_ff <= 34'(mul_q);
            bbi_pkg::ST_ARM: begin
               vel_ff[axis_ff] <= bbi_pkg::sat32(72'(gv_ff) + 72'(mul_q));
            end
            bbi_pkg::ST_SQ: begin
               sq_ff <= ((axis_ff == 2'd0) ? 66'd0 : sq_ff) + 66'(mul_p[63:0]);
            end
            bbi_pkg::ST_CMP: fast_ff <= sq_ff > SpeedSq;
            default: begin
            end
         endcase
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.pos_x        = pos_ff[0];
   assign rsp.pos_y        = pos_ff[1];
   assign rsp.pos_z        = pos_ff[2];
   assign rsp.vel_x        = vel_ff[0];
   assign rsp.vel_y        = vel_ff[1];
   assign rsp.vel_z        = vel_ff[2];
   assign rsp.airborne     = fly_ff;
   assign rsp.moving       = fast_ff;
   assign rsp.since_impact = timer_ff;

endmodule

[tb/bbi_test_if.sv]
`timescale 1ns / 1ps
package bbi_test_pkg;

   typedef struct {
      bbi_pkg::mode_type  mode;
      logic [16:0]        time_step;
      logic signed [31:0] force_v [3];
      logic [21:0]        charge_time;
      logic signed [31:0] place_v [3];
   } step_item_type;

   typedef struct {
      logic signed [31:0] pos [3];
      logic signed [31:0] vel [3];
      logic               airborne;
      logic               moving;
      logic [30:0]        since_impact;
   } ball_state_type;
endpackage

[tb/ballistic_ball_integrator_test.sv]
`timescale 1ns / 1ps
module ballistic_ball_integrator_test;

   // Predicts the ball state after every accepted item and keeps the
   // predictions in order until the matching result comes out.
   class ball_scoreboard;
      longint gravity_q, drag_q, wind_q[3], keep_q, self_gain_q, arm_gain_q;
      logic signed [31:0] pos_s [3];
      logic signed [31:0] vel_s [3];
      bit flying_s, fast_s;
      longint unsigned timer_s;
      bbi_test_pkg::ball_state_type pending_states[$];
      int mismatches;
      int results_seen;

      function new();
         gravity_q = 642689; drag_q = 92;
         wind_q[0] = 0; wind_q[1] = 0; wind_q[2] = 0;
         keep_q = 32768; self_gain_q = -30583; arm_gain_q = 38229;
         foreach (pos_s[i]) begin
            pos_s[i] = 0;
            vel_s[i] = 0;
         end
         flying_s = 0; fast_s = 0; timer_s = 0;
         mismatches = 0; results_seen = 0;
      endfunction

      function void write_reg(bbi_pkg::reg_index_type idx, logic [31:0] value);
         case (idx)
            bbi_pkg::REG_GRAVITY: gravity_q = longint'(value[20:0]);
            bbi_pkg::REG_DRAG:    drag_q = longint'(value[15:0]);
            bbi_pkg::REG_WIND_X:  wind_q[0] = longint'(signed'(value));
            bbi_pkg::REG_WIND_Y:  wind_q[1] = longint'(signed'(value));
            bbi_pkg::REG_WIND_Z:  wind_q[2] = longint'(signed'(value));
            bbi_pkg::REG_KEEP:    keep_q = longint'(value[16:0]);
            bbi_pkg::REG_SELF:    self_gain_q = longint'(signed'(value[17:0]));
            bbi_pkg::REG_ARM:     arm_gain_q = longint'(value[20:0]);
         endcase
      endfunction

      // Arithmetic shift is a floor for negative values, as required.
      function longint qmul(longint a, longint b);
         return (a * b) >>> 16;
      endfunction

      function longint clip32(longint x);
         if (x > 64'sd2147483647) return 64'sd2147483647;
         if (x < -64'sd2147483648) return -64'sd2147483648;
         return x;
      endfunction

      function void refresh_moving();
         longint unsigned sum;
         longint v;
         sum = 0;
         for (int i = 0; i < 3; i++) begin
            v = longint'(vel_s[i]);
            sum += longint'(v * v);
         end
         fast_s = sum > 64'd6554 * 64'd6554;
      endfunction

      function void note_item(bbi_test_pkg::step_item_type it);
         longint dt, a, adt, stride, v;
         bbi_test_pkg::ball_state_type s;
         dt = longint'(it.time_step);
         case (it.mode)
            bbi_pkg::MODE_TICK: begin
               timer_s = timer_s + dt;
               if (timer_s > 64'h7FFFFFFF) timer_s = 64'h7FFFFFFF;
               if (flying_s) begin
                  for (int i = 0; i < 3; i++) begin
                     v = longint'(vel_s[i]);
                     a = wind_q[i];
                     if (fast_s) a -= qmul(drag_q, v);
                     if (i == 1) a -= gravity_q;
                     a = clip32(a);
                     adt = clip32(qmul(a, dt));
                     stride = clip32(qmul(v, dt)) + ((adt * dt) >>> 17);
                     vel_s[i] = 32'(clip32(v + adt));
                     pos_s[i] = 32'(clip32(longint'(pos_s[i]) + stride));
                  end
                  refresh_moving();
               end
            end
            bbi_pkg::MODE_BOUNCE: begin
               timer_s = 0;
               if (flying_s) begin
                  for (int i = 0; i < 3; i++) begin
                     v = qmul(longint'(vel_s[i]), keep_q);
                     if (i == 1) v = -v;
                     vel_s[i] = 32'(clip32(v));
                  end
                  refresh_moving();
               end
            end
            bbi_pkg::MODE_PLACE: begin
               timer_s = 0;
               for (int i = 0; i < 3; i++) begin
                  vel_s[i] = 0;
                  pos_s[i] = it.place_v[i];
               end
               fast_s = 0;
               flying_s = 0;
            end
            default: begin
               timer_s = 0;
               for (int i = 0; i < 3; i++) begin
                  a = clip32(qmul(longint'(it.force_v[i]), longint'(it.charge_time)));
                  vel_s[i] = 32'(clip32(qmul(self_gain_q, longint'(vel_s[i]))
                                        + qmul(arm_gain_q, a)));
               end
               flying_s = 1;
               refresh_moving();
            end
         endcase
         s.pos = pos_s;
         s.vel = vel_s;
         s.airborne = flying_s;
         s.moving = fast_s;
         s.since_impact = timer_s[30:0];
         pending_states.push_back(s);
      endfunction

      function void check_result(bbi_test_pkg::ball_state_type got);
         bbi_test_pkg::ball_state_type want;
         bit bad;
         results_seen++;
         if (pending_states.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result with no item outstanding");
            return;
         end
         want = pending_states.pop_front();
         bad = (got.airborne !== want.airborne) || (got.moving !== want.moving) ||
               (got.since_impact !== want.since_impact);
         for (int i = 0; i < 3; i++) begin
            if (got.pos[i] !== want.pos[i] || got.vel[i] !== want.vel[i]) bad = 1;
         end
         if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("Result %0d differs: expected pos %0d %0d %0d vel %0d %0d %0d",
                        results_seen, want.pos[0], want.pos[1], want.pos[2], want.vel[0],
                        want.vel[1], want.vel[2]);
               $display("   expected a%0b m%0b t%0d", want.airborne, want.moving,
                        want.since_impact);
               $display("   got pos %0d %0d %0d vel %0d %0d %0d a%0b m%0b t%0d",
                        got.pos[0], got.pos[1], got.pos[2], got.vel[0], got.vel[1],
                        got.vel[2], got.airborne, got.moving, got.since_impact);
            end
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;

   always #4 clock = ~clock;

   bbi_req_if req_ch ();
   bbi_rsp_if rsp_ch ();
   bbi_csr_if csr_ch ();

   ballistic_ball_integrator i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source),
      .csr   (csr_ch.sink)
   );

   ball_scoreboard ball_model = new();

   // When set, neither side idles; used in the closing part of the run.
   bit no_idle = 0;
   int hits_sent = 0, ticks_sent = 0, places_sent = 0, bounces_sent = 0;

   initial begin
      req_ch.valid <= 0;
      req_ch.mode <= bbi_pkg::MODE_TICK;
      req_ch.time_step <= 0;
      req_ch.arm_force_x <= 0;
      req_ch.arm_force_y <= 0;
      req_ch.arm_force_z <= 0;
      req_ch.charge_time <= 0;
      req_ch.place_x <= 0;
      req_ch.place_y <= 0;
      req_ch.place_z <= 0;
      csr_ch.valid <= 0;
      csr_ch.index <= bbi_pkg::REG_GRAVITY;
      csr_ch.data <= 0;
      rsp_ch.ready <= 0;
   end

   // The result side is ready most of the time, with random stall bursts.
   // Each result is sampled at the edge where it is accepted.
   initial begin
      int stall;
      @(posedge clock iff !reset);
      forever begin
         if (!no_idle && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 19);
            rsp_ch.ready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1;
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            bbi_test_pkg::ball_state_type got;
            got.pos[0] = rsp_ch.pos_x;
            got.pos[1] = rsp_ch.pos_y;
            got.pos[2] = rsp_ch.pos_z;
            got.vel[0] = rsp_ch.vel_x;
            got.vel[1] = rsp_ch.vel_y;
            got.vel[2] = rsp_ch.vel_z;
            got.airborne = rsp_ch.airborne;
            got.moving = rsp_ch.moving;
            got.since_impact = rsp_ch.since_impact;
            ball_model.check_result(got);
         end
      end
   end

   // Holds one register write until it is accepted; valid stays high for a
   // following write and is lowered by the caller. Only used while idle.
   task automatic write_register(bbi_pkg::reg_index_type idx, logic [31:0] value);
      csr_ch.valid <= 1;
      csr_ch.index <= idx;
      csr_ch.data <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      ball_model.write_reg(idx, value);
   endtask

   // Presents one item, possibly after an idle burst, and holds it until accepted.
   task automatic send_item(bbi_test_pkg::step_item_type it);
      if (!no_idle && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.mode <= it.mode;
      req_ch.time_step <= it.time_step;
      req_ch.arm_force_x <= it.force_v[0];
      req_ch.arm_force_y <= it.force_v[1];
      req_ch.arm_force_z <= it.force_v[2];
      req_ch.charge_time <= it.charge_time;
      req_ch.place_x <= it.place_v[0];
      req_ch.place_y <= it.place_v[1];
      req_ch.place_z <= it.place_v[2];
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      ball_model.note_item(it);
      case (it.mode)
         bbi_pkg::MODE_TICK:   ticks_sent++;
         bbi_pkg::MODE_BOUNCE: bounces_sent++;
         bbi_pkg::MODE_PLACE:  places_sent++;
         default:              hits_sent++;
      endcase
   endtask

   // Lowers valid after the last item of a phase and waits until all
   // results are back, plus a margin for the longest operation.
   task automatic drain();
      req_ch.valid <= 0;
      while (ball_model.pending_states.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic bbi_test_pkg::step_item_type make_item(bbi_pkg::mode_type m,
                                                             logic [16:0] dt,
                                                             logic [21:0] ct,
                                                             logic [31:0] f,
                                                             logic [31:0] p);
      bbi_test_pkg::step_item_type it;
      it.mode = m;
      it.time_step = dt;
      it.charge_time = ct;
      for (int i = 0; i < 3; i++) begin
         it.force_v[i] = f;
         it.place_v[i] = p;
      end
      return it;
   endfunction

   // Random item. Mostly realistic play: small forces and steps so the ball
   // actually flies, bounces and keeps moving; the rest uses full-range fields.
   function automatic bbi_test_pkg::step_item_type random_item();
      bbi_test_pkg::step_item_type it;
      int sel;
      bit wide;
      sel = $urandom_range(0, 99);
      wide = $urandom_range(0, 7) == 0;
      if (sel < 55) it.mode = bbi_pkg::MODE_TICK;
      else if (sel < 70) it.mode = bbi_pkg::MODE_BOUNCE;
      else if (sel < 80) it.mode = bbi_pkg::MODE_PLACE;
      else it.mode = bbi_pkg::MODE_HIT;
      it.time_step = wide ? 17'($urandom_range(0, 131071)) : 17'($urandom_range(0, 8000));
      it.charge_time = wide ? 22'($urandom) : 22'($urandom_range(0, 200000));
      for (int i = 0; i < 3; i++) begin
         it.force_v[i] = wide ? 32'($urandom) : 32'($urandom_range(0, 4000000)) - 32'd2000000;
         it.place_v[i] = wide ? 32'($urandom) : 32'($urandom_range(0, 2000000)) - 32'd1000000;
      end
      return it;
   endfunction

   // Register settings: reset values, then the extremes, then random ones.
   task automatic set_registers(int setting);
      case (setting)
         0: begin
            write_register(bbi_pkg::REG_GRAVITY, 642689);
            write_register(bbi_pkg::REG_DRAG, 92);
            write_register(bbi_pkg::REG_WIND_X, 0);
            write_register(bbi_pkg::REG_WIND_Y, 0);
            write_register(bbi_pkg::REG_WIND_Z, 0);
            write_register(bbi_pkg::REG_KEEP, 32768);
            write_register(bbi_pkg::REG_SELF, 32'h3FFFF & (-30583));
            write_register(bbi_pkg::REG_ARM, 38229);
         end
         1: begin
            write_register(bbi_pkg::REG_GRAVITY, 32'h1FFFFF);
            write_register(bbi_pkg::REG_DRAG, 32'hFFFF);
            write_register(bbi_pkg::REG_WIND_X, 32'h7FFFFFFF);
            write_register(bbi_pkg::REG_WIND_Y, 32'h80000000);
            write_register(bbi_pkg::REG_WIND_Z, 32'h7FFFFFFF);
            write_register(bbi_pkg::REG_KEEP, 32'h10000);
            write_register(bbi_pkg::REG_SELF, 32'h10000);
            write_register(bbi_pkg::REG_ARM, 32'h100000);
         end
         2: begin
            write_register(bbi_pkg::REG_GRAVITY, 0);
            write_register(bbi_pkg::REG_DRAG, 0);
            write_register(bbi_pkg::REG_WIND_X, 32'h80000000);
            write_register(bbi_pkg::REG_WIND_Y, 32'h7FFFFFFF);
            write_register(bbi_pkg::REG_WIND_Z, 32'h80000000);
            write_register(bbi_pkg::REG_KEEP, 0);
            write_register(bbi_pkg::REG_SELF, 32'h30000);
            write_register(bbi_pkg::REG_ARM, 0);
         end
         default: begin
            // Register values wider than a field are legal; only the field's low bits are kept.
            write_register(bbi_pkg::REG_GRAVITY, $urandom_range(0, 2000000));
            write_register(bbi_pkg::REG_DRAG, $urandom_range(0, 65535));
            write_register(bbi_pkg::REG_WIND_X, $urandom_range(0, 400000) - 200000);
            write_register(bbi_pkg::REG_WIND_Y, $urandom_range(0, 400000) - 200000);
            write_register(bbi_pkg::REG_WIND_Z, $urandom);
            write_register(bbi_pkg::REG_KEEP, $urandom_range(0, 131071));
            write_register(bbi_pkg::REG_SELF, $urandom);
            write_register(bbi_pkg::REG_ARM, $urandom_range(0, 2097151));
         end
      endcase
      csr_ch.valid <= 0;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed items under the reset settings.
      send_item(make_item(bbi_pkg::MODE_TICK, 17'h10000, 0, 0, 0));     // landed tick
      send_item(make_item(bbi_pkg::MODE_BOUNCE, 0, 0, 0, 0));           // bounce while landed
      send_item(make_item(bbi_pkg::MODE_PLACE, 0, 0, 0, 32'h7FFFFFFF));
      send_item(make_item(bbi_pkg::MODE_PLACE, 0, 0, 0, 32'h80000000));
      send_item(make_item(bbi_pkg::MODE_HIT, 0, 22'd65536, 32'h00030000, 0));
      send_item(make_item(bbi_pkg::MODE_TICK, 17'd1092, 0, 0, 0));
      send_item(make_item(bbi_pkg::MODE_TICK, 17'h10000, 0, 0, 0));
      send_item(make_item(bbi_pkg::MODE_BOUNCE, 0, 0, 0, 0));
      send_item(make_item(bbi_pkg::MODE_HIT, 0, 22'h3FFFFF, 32'h7FFFFFFF, 0));
      send_item(make_item(bbi_pkg::MODE_TICK, 17'h1FFFF, 0, 0, 0));
      send_item(make_item(bbi_pkg::MODE_HIT, 0, 22'h3FFFFF, 32'h80000000, 0));
      send_item(make_item(bbi_pkg::MODE_BOUNCE, 0, 0, 0, 0));
      send_item(make_item(bbi_pkg::MODE_TICK, 0, 0, 0, 0));
      send_item(make_item(bbi_pkg::MODE_PLACE, 0, 0, 0, 0));
      // Long landed ticks build up the time since impact.
      repeat (8) send_item(make_item(bbi_pkg::MODE_TICK, 17'h1FFFF, 0, 0, 0));
      drain();

      // Extreme settings: a most negative velocity gets negated on a bounce.
      set_registers(2);
      send_item(make_item(bbi_pkg::MODE_HIT, 0, 22'h3FFFFF, 32'h80000000, 0));
      send_item(make_item(bbi_pkg::MODE_BOUNCE, 0, 0, 0, 0));
      drain();
      set_registers(1);
      send_item(make_item(bbi_pkg::MODE_HIT, 0, 22'h3FFFFF, 32'h80000000, 0));
      send_item(make_item(bbi_pkg::MODE_BOUNCE, 0, 0, 0, 0));
      send_item(make_item(bbi_pkg::MODE_TICK, 17'h1FFFF, 0, 0, 0));
      drain();

      // Random phases with changing settings; the last phase runs without idling.
      for (int phase = 0; phase < 8; phase++) begin
         set_registers(phase == 0 ? 0 : 3 + phase);
         if (phase == 7) no_idle = 1;
         repeat (180) send_item(random_item());
         drain();
      end

      $display("Covered %0d ticks, %0d bounces, %0d places and %0d arm hits over %0d results.",
               ticks_sent, bounces_sent, places_sent, hits_sent, ball_model.results_seen);
      if (ball_model.mismatches == 0 && ball_model.pending_states.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("Mismatches: %0d", ball_model.mismatches);
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("Timeout with %0d results outstanding", ball_model.pending_states.size());
      $display("*** FAILED ***");
      $finish;
   end
endmodule

[files.f]
rtl/bbi_pkg.sv
rtl/bbi_if.sv
rtl/ballistic_ball_integrator.sv
tb/bbi_test_if.sv
tb/ballistic_ball_integrator_test.sv
